>>> rtl/sfir33_pkg.sv
`default_nettype none

package sfir33_pkg;

    // Filter geometry
    localparam int TAPS             = 33;
    localparam int HALF_TAPS        = TAPS / 2;
    localparam int PTR_W            = $clog2(TAPS);
    localparam int K_W              = $clog2(HALF_TAPS + 1);
    localparam int COEF_W           = 12;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int OUT_W            = 32;

    // Final scaling: divide by 2**DIV_SHIFT, truncating toward zero
    localparam int DIV_SHIFT        = 6;

    // Coefficient of symmetric pair k (k = HALF_TAPS is the center tap)
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [K_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            5'd0:    c = -12'sd23;
            5'd1:    c = -12'sd16;
            5'd2:    c = -12'sd5;
            5'd3:    c = 12'sd9;
            5'd4:    c = 12'sd16;
            5'd5:    c = -12'sd4;
            5'd6:    c = -12'sd70;
            5'd7:    c = -12'sd184;
            5'd8:    c = -12'sd317;
            5'd9:    c = -12'sd406;
            5'd10:   c = -12'sd374;
            5'd11:   c = -12'sd161;
            5'd12:   c = 12'sd241;
            5'd13:   c = 12'sd770;
            5'd14:   c = 12'sd1306;
            5'd15:   c = 12'sd1706;
            5'd16:   c = 12'sd1854;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Ring index stepping, modulo TAPS
    function automatic logic [PTR_W-1:0] idx_inc(input logic [PTR_W-1:0] i);
        return (i == PTR_W'(TAPS - 1)) ? '0 : i + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] idx_dec(input logic [PTR_W-1:0] i);
        return (i == '0) ? PTR_W'(TAPS - 1) : i - PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/symmetric_fir_33tap_lowpass_unit.sv
`default_nettype none

// 33-tap symmetric low-pass FIR for signed pulse sensor samples.
//
// Input stream (s_*): one sample per transfer in s_tdata. Output stream
// (m_*): one filtered value per input sample, in order, in m_tdata.
//
// Each accepted sample is written into a 33-entry sample ring. A sequencer
// then steps one pre-add / multiply / accumulate datapath through the 16
// symmetric pairs and the center tap, one tap per cycle, reading two ring
// entries per cycle. The sum is divided by 64 toward zero and loaded into
// the output register.
//
// The block takes no new sample before it is done with the last one: the 17
// tap steps of the shared multiply-accumulate unit run first, and s_tready is
// high only while the sequencer is idle.
//
// Reset clears the ring (through per-entry valid bits, no sweep), the write
// pointer and all control state. A stalled receiver holds the result in the
// output register; a new sample is still taken meanwhile, and its result
// waits in the accumulator until the output register frees.
module symmetric_fir_33tap_lowpass_unit #(
    parameter int SAMPLE_WIDTH = sfir33_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata fields, low bit up: sample
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8)*8-1:0] s_tdata,
    // m_tdata fields, low bit up: filtered
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sfir33_pkg::OUT_W-1:0]          m_tdata
);

    import sfir33_pkg::*;

    localparam int PAIR_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = PAIR_W + COEF_W;
    localparam int ACC_W  = SAMPLE_WIDTH + 16;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    logic [PTR_W-1:0]           newer_reg, newer_next;
    logic [PTR_W-1:0]           older_reg, older_next;
    logic [K_W-1:0]             k_reg, k_next;

    logic [SAMPLE_WIDTH-1:0]    ring_mem [TAPS];
    logic [TAPS-1:0]            ring_vld_reg;

    logic                       s1_vld_reg, s1_last_reg;
    logic [K_W-1:0]             s1_k_reg;
    logic [SAMPLE_WIDTH-1:0]    rd_a_reg, rd_b_reg;

    logic                       s2_vld_reg, s2_last_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       out_vld_reg, out_vld_next;
    logic [OUT_W-1:0]           out_data_reg;

    logic                       in_xfer;
    logic                       issue;
    logic                       mid_tap;
    logic                       out_free;
    logic                       out_load;
    logic signed [PAIR_W-1:0]   pair;
    logic signed [COEF_W-1:0]   coef;
    logic signed [ACC_W-1:0]    acc_adj;
    logic signed [ACC_W-1:0]    quot;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign issue    = (state_reg == S_ISSUE);
    assign mid_tap  = (k_reg == K_W'(HALF_TAPS));
    assign out_free = !out_vld_reg || m_tready;
    assign out_load = (state_reg == S_FINISH) && out_free;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        newer_next = newer_reg;
        older_next = older_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    newer_next = ptr_reg;
                    older_next = idx_inc(ptr_reg);
                    ptr_next   = idx_inc(ptr_reg);
                    k_next     = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (mid_tap)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    newer_next = idx_dec(newer_reg);
                    older_next = idx_inc(older_reg);
                end
            end
            S_DRAIN:
            begin
                if (s2_vld_reg && s2_last_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            newer_reg <= '0;
            older_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            newer_reg <= newer_next;
            older_reg <= older_next;
            k_reg     <= k_next;
        end
    end

    // Sample ring: write on input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ring_mem[ptr_reg] <= s_tdata[SAMPLE_WIDTH-1:0];
        end
    end

    // Entry valid bits; an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
        end
        else if (in_xfer)
        begin
            ring_vld_reg[ptr_reg] <= 1'b1;
        end
    end

    // Stage 1: registered ring reads, the older and newer sample of a pair
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_a_reg <= ring_vld_reg[older_reg] ? ring_mem[older_reg] : '0;
            rd_b_reg <= (ring_vld_reg[newer_reg] && !mid_tap) ? ring_mem[newer_reg] : '0;
            s1_k_reg <= k_reg;
        end
    end

    // Stage 2: pre-add and multiply by the pair coefficient
    assign pair = {rd_a_reg[SAMPLE_WIDTH-1], rd_a_reg} + {rd_b_reg[SAMPLE_WIDTH-1], rd_b_reg};
    assign coef = coef_at(s1_k_reg);

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            prod_reg <= pair * coef;
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= issue;
            s1_last_reg <= issue && mid_tap;
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: accumulate; clear on a new sample
    always_comb
    begin
        acc_next = acc_reg;
        if (in_xfer)
        begin
            acc_next = '0;
        end
        else if (s2_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Divide by 64 toward zero: bias negative sums before the shift
    assign acc_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'((1 << DIV_SHIFT) - 1) : ACC_W'(0));
    assign quot    = acc_adj >>> DIV_SHIFT;

    // Output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= OUT_W'(quot);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Last product lands only while the sequencer drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && s2_last_reg) |-> (state_reg == S_DRAIN))
        else $error("last tap product outside drain");

    // Write pointer stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg < PTR_W'(TAPS))
        else $error("write pointer out of range");

    // No tap in flight while a new sample can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("tap pipeline busy in idle");

    // A finished sum reaches the output register once it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("result not presented after load");
`endif

endmodule

`default_nettype wire

>>> tb/sv/fir_stream_checker.sv
`timescale 1ns / 1ps

module fir_stream_checker #(
    parameter int SAMPLE_WIDTH = sfir33_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // s_tdata fields, low bit up: sample
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8)*8-1:0] s_tdata,
    // m_tdata fields, low bit up: filtered
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [sfir33_pkg::OUT_W-1:0]          m_tdata,
    output int                                    fail_count,
    output int                                    pending
);

    localparam int TAPS      = sfir33_pkg::TAPS;
    localparam int HALF_TAPS = sfir33_pkg::HALF_TAPS;
    localparam int OUT_W     = sfir33_pkg::OUT_W;

    // Past samples and the slot that takes the next one
    logic signed [SAMPLE_WIDTH-1:0] sample_history [TAPS];
    int                             next_slot;

    logic [OUT_W-1:0] expected_filtered [$];

    // Weight of symmetric pair k; k = HALF_TAPS is the center tap
    function automatic longint pair_weight(input int k);
        case (k)
            0:       return -23;
            1:       return -16;
            2:       return -5;
            3:       return 9;
            4:       return 16;
            5:       return -4;
            6:       return -70;
            7:       return -184;
            8:       return -317;
            9:       return -406;
            10:      return -374;
            11:      return -161;
            12:      return 241;
            13:      return 770;
            14:      return 1306;
            15:      return 1706;
            16:      return 1854;
            default: return 0;
        endcase
    endfunction

    // Weighted sum over the history, newest sample at next_slot, scaled by 1/64
    function automatic logic [OUT_W-1:0] filter_response();
        longint acc;
        longint pair;
        int     newer;
        int     older;
        acc   = 0;
        newer = next_slot;
        older = (next_slot + 1) % TAPS;
        for (int k = 0; k < HALF_TAPS; k++)
        begin
            pair  = longint'(sample_history[newer]) + longint'(sample_history[older]);
            acc  += pair * pair_weight(k);
            newer = (newer == 0) ? TAPS - 1 : newer - 1;
            older = (older + 1) % TAPS;
        end
        acc += longint'(sample_history[older]) * pair_weight(HALF_TAPS);
        // longint division truncates toward zero
        return OUT_W'(acc / 64);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                sample_history[i] = '0;
            next_slot = 0;
            expected_filtered.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Compare each output transfer with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_filtered.size() == 0)
                begin
                    $error("filtered: no result expected, actual %0d", $signed(m_tdata));
                    fail_count <= fail_count + 1;
                end
                else if (m_tdata !== expected_filtered[0])
                begin
                    $error("filtered: expected %0d, actual %0d",
                           $signed(expected_filtered[0]), $signed(m_tdata));
                    fail_count <= fail_count + 1;
                    void'(expected_filtered.pop_front());
                end
                else
                    void'(expected_filtered.pop_front());
            end

            // Store each input transfer, predict its result, advance the slot
            if (s_tvalid && s_tready)
            begin
                sample_history[next_slot] = s_tdata[SAMPLE_WIDTH-1:0];
                expected_filtered.push_back(filter_response());
                next_slot = (next_slot == TAPS - 1) ? 0 : next_slot + 1;
            end

            pending <= expected_filtered.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_W    = sfir33_pkg::SAMPLE_WIDTH_DEF;
    localparam int DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int TAPS        = sfir33_pkg::TAPS;
    localparam int HALF_TAPS   = sfir33_pkg::HALF_TAPS;
    localparam int STALL_LIMIT = 5000;

    localparam logic [DATA_W-1:0] SAMPLE_MAX = DATA_W'(24'h7FFFFF);
    localparam logic [DATA_W-1:0] SAMPLE_MIN = DATA_W'(24'h800000);

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [DATA_W-1:0]              s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sfir33_pkg::OUT_W-1:0]   m_tdata;

    int send_idle    = 34;
    int recv_idle    = 60;
    int sent_items   = 0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;

    always #5 clk = ~clk;

    symmetric_fir_33tap_lowpass_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fir_stream_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Apply random backpressure on the output stream
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one sample, with random gaps, and hold it until the transfer
    task automatic push_sample(input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
    endtask

    function automatic bit weight_positive(input int k);
        case (k)
            3, 4, 12, 13, 14, 15, 16: return 1'b1;
            default:                  return 1'b0;
        endcase
    endfunction

    // Fill the whole history with near-full-scale samples signed like the taps,
    // driving the output toward its largest magnitude
    task automatic full_scale_burst();
        bit                positive;
        int                k;
        logic [DATA_W-1:0] jitter;
        positive = 1'($urandom_range(1));
        for (int i = 0; i < TAPS; i++)
        begin
            k      = (i <= HALF_TAPS) ? i : TAPS - 1 - i;
            jitter = ($urandom_range(1) == 0) ? '0 : DATA_W'($urandom_range(4095));
            if (weight_positive(k) == positive)
                push_sample(SAMPLE_MAX - jitter);
            else
                push_sample(SAMPLE_MIN + jitter);
        end
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 68)
            push_sample(DATA_W'($urandom()));
        else if (pick < 80)
        begin
            case ($urandom_range(4))
                0:       push_sample(SAMPLE_MAX);
                1:       push_sample(SAMPLE_MIN);
                2:       push_sample('0);
                3:       push_sample('1);
                default: push_sample(DATA_W'(1));
            endcase
        end
        else if (pick < 92)
            push_sample(DATA_W'($urandom_range(255)) - DATA_W'(128));
        else
            full_scale_burst();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, sign edges, small negatives that truncate toward zero
        push_sample('0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample('1);
        push_sample(DATA_W'(1));
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MIN);
        push_sample(DATA_W'(24'h555555));
        push_sample(DATA_W'(24'hAAAAAA));
        push_sample(DATA_W'(24'hFFFFFE));
        push_sample(DATA_W'(2));
        push_sample(DATA_W'(24'hFFFFFD));
        push_sample(DATA_W'(24'h000040));
        push_sample('0);

        // Random: sender idles less than receiver
        while (sent_items < 640)
            random_item();

        // Random: receiver idles less than sender
        send_idle = 60;
        recv_idle = 34;
        while (sent_items < 1260)
            random_item();

        // Random: full rate on both sides
        send_idle = 0;
        recv_idle = 0;
        while (sent_items < 1850)
            random_item();
        s_tvalid <= 1'b0;

        // Let the checker record the last transfer before polling its queue
        @(posedge clk);

        // Drain outstanding results, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> symmetric_fir_33tap_lowpass_unit.f
rtl/sfir33_pkg.sv
rtl/symmetric_fir_33tap_lowpass_unit.sv
tb/sv/fir_stream_checker.sv
tb/sv/tb.sv
